// File: hw/rtl/soc_pkg.sv
// shared types and constants for the segment obstacle clearance check
// no dependencies; imported by soc_cell and segment_obstacle_clearance_check
`timescale 1ns / 1ps

package soc_pkg;

    // fixed field widths of the item and result ports
    localparam int FIELD_W = 16;
    localparam int SLOT_W  = 10;
    localparam int COUNT_W = 11;
    localparam int HIT_W   = 10;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // chain shape: table entries are interleaved over the cells by low index bits
    localparam int CELLS     = 4;
    localparam int CELL_BITS = 2;
    localparam int CELL_LAT  = 4;
    localparam int CHAIN_LAT = CELLS * CELL_LAT;

    // item commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // register index of segment_count
    localparam logic REG_SEG_COUNT = 1'b0;

    // orientation codes
    typedef logic [1:0] t_turn;
    localparam t_turn TURN_COL = 2'd0;
    localparam t_turn TURN_POS = 2'd1;
    localparam t_turn TURN_NEG = 2'd2;

    // scan token flags handed from cell to cell
    typedef struct packed {
        logic valid;
        logic hit;
    } t_tok;

endpackage

// File: hw/rtl/soc_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module soc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/soc_cell.sv
// one cell of the scan chain: holds a bank of the obstacle table and tests
// the query segment against one entry per token; depends on soc_pkg, soc_ram
`timescale 1ns / 1ps

module soc_cell #(
    parameter int CW = 16,
    parameter int BANK_DEPTH = 256,
    parameter int BA_W = 8,
    parameter int CNT_W = 11,
    parameter int CELL_ID = 0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_we,
    input  logic [BA_W-1:0]                  i_waddr,
    input  logic [4*CW-1:0]                  i_wdata,
    input  logic [4*CW-1:0]                  i_query,
    input  logic [CNT_W-1:0]                 i_count,
    input  soc_pkg::t_tok                    i_tok,
    input  logic [BA_W-1:0]                  i_step,
    input  logic [BA_W+soc_pkg::CELL_BITS-1:0] i_idx,
    output soc_pkg::t_tok                    o_tok,
    output logic [BA_W-1:0]                  o_step,
    output logic [BA_W+soc_pkg::CELL_BITS-1:0] o_idx
);

    import soc_pkg::*;

    localparam int IDX_W = BA_W + CELL_BITS;
    localparam int DW = CW + 1;
    localparam int PW = 2 * CW + 2;
    localparam int VW = 2 * CW + 3;

    function automatic logic signed [CW:0] f_sub(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
        f_sub = {a[CW-1], a} - {b[CW-1], b};
    endfunction

    // q lies between p and r on one axis
    function automatic logic f_between(input logic signed [CW-1:0] q,
                                       input logic signed [CW-1:0] p,
                                       input logic signed [CW-1:0] r);
        f_between = (q <= p || q <= r) && (q >= p || q >= r);
    endfunction

    logic [4*CW-1:0] w_rdata;

    // table bank
    soc_ram #(
        .WIDTH (4 * CW),
        .DEPTH (BANK_DEPTH),
        .ADDR_W(BA_W)
    ) u_bank (
        .i_clk  (i_clk),
        .i_we   (i_we),
        .i_waddr(i_waddr),
        .i_wdata(i_wdata),
        .i_raddr(i_step),
        .o_rdata(w_rdata)
    );

    // query endpoints a, b and stored endpoints c, d
    logic signed [CW-1:0] w_ax, w_ay, w_bx, w_by;
    logic signed [CW-1:0] w_cx, w_cy, w_dx, w_dy;

    assign w_ax = i_query[4*CW-1:3*CW];
    assign w_ay = i_query[3*CW-1:2*CW];
    assign w_bx = i_query[2*CW-1:CW];
    assign w_by = i_query[CW-1:0];
    assign w_cx = w_rdata[4*CW-1:3*CW];
    assign w_cy = w_rdata[3*CW-1:2*CW];
    assign w_dx = w_rdata[2*CW-1:CW];
    assign w_dy = w_rdata[CW-1:0];

    // stage a: token alongside the bank read
    t_tok             r_a_tok;
    logic [BA_W-1:0]  r_a_step;
    logic [IDX_W-1:0] r_a_idx;

    // stage b: differences, box tests, live flag
    t_tok                  r_b_tok;
    logic [BA_W-1:0]       r_b_step;
    logic [IDX_W-1:0]      r_b_idx;
    logic [IDX_W-1:0]      r_b_ent;
    logic                  r_b_live;
    logic [3:0]            r_b_box;
    logic signed [DW-1:0]  r_b_ma [8];
    logic signed [DW-1:0]  r_b_mb [8];

    // stage c: products
    t_tok                  r_c_tok;
    logic [BA_W-1:0]       r_c_step;
    logic [IDX_W-1:0]      r_c_idx;
    logic [IDX_W-1:0]      r_c_ent;
    logic                  r_c_live;
    logic [3:0]            r_c_box;
    logic signed [PW-1:0]  r_c_p [8];

    // stage d: token leaving the cell
    t_tok             r_d_tok;
    logic [BA_W-1:0]  r_d_step;
    logic [IDX_W-1:0] r_d_idx;

    logic [IDX_W-1:0]     w_ent;
    logic                 w_live;
    logic [3:0]           w_box;
    logic signed [DW-1:0] w_ma [8];
    logic signed [DW-1:0] w_mb [8];
    logic signed [VW-1:0] w_v [4];
    t_turn                w_turn [4];
    logic                 w_touch;

    // entry index under test and whether it lies below the count
    assign w_ent  = {r_a_step, CELL_BITS'(CELL_ID)};
    assign w_live = (32'(w_ent) < 32'(i_count));

    // collinear endpoint inside the other segment's bounding box
    assign w_box[0] = f_between(w_cx, w_ax, w_bx) && f_between(w_cy, w_ay, w_by);
    assign w_box[1] = f_between(w_dx, w_ax, w_bx) && f_between(w_dy, w_ay, w_by);
    assign w_box[2] = f_between(w_ax, w_cx, w_dx) && f_between(w_ay, w_cy, w_dy);
    assign w_box[3] = f_between(w_bx, w_cx, w_dx) && f_between(w_by, w_cy, w_dy);

    // multiplier operands for the four cross products
    always_comb begin
        w_ma[0] = f_sub(w_by, w_ay);  w_mb[0] = f_sub(w_cx, w_bx);
        w_ma[1] = f_sub(w_bx, w_ax);  w_mb[1] = f_sub(w_cy, w_by);
        w_ma[2] = f_sub(w_by, w_ay);  w_mb[2] = f_sub(w_dx, w_bx);
        w_ma[3] = f_sub(w_bx, w_ax);  w_mb[3] = f_sub(w_dy, w_by);
        w_ma[4] = f_sub(w_dy, w_cy);  w_mb[4] = f_sub(w_ax, w_dx);
        w_ma[5] = f_sub(w_dx, w_cx);  w_mb[5] = f_sub(w_ay, w_dy);
        w_ma[6] = f_sub(w_dy, w_cy);  w_mb[6] = f_sub(w_bx, w_dx);
        w_ma[7] = f_sub(w_dx, w_cx);  w_mb[7] = f_sub(w_by, w_dy);
    end

    // orientation of each cross product and the touch decision
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_v[k] = {r_c_p[2*k][PW-1], r_c_p[2*k]} - {r_c_p[2*k+1][PW-1], r_c_p[2*k+1]};
            if (w_v[k] == '0) begin
                w_turn[k] = TURN_COL;
            end else if (w_v[k][VW-1] == 1'b0) begin
                w_turn[k] = TURN_POS;
            end else begin
                w_turn[k] = TURN_NEG;
            end
        end
        w_touch = (w_turn[0] != w_turn[1] && w_turn[2] != w_turn[3])
               || (w_turn[0] == TURN_COL && r_c_box[0])
               || (w_turn[1] == TURN_COL && r_c_box[1])
               || (w_turn[2] == TURN_COL && r_c_box[2])
               || (w_turn[3] == TURN_COL && r_c_box[3]);
    end

    // token flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tok <= '0;
            r_b_tok <= '0;
            r_c_tok <= '0;
            r_d_tok <= '0;
        end else begin
            r_a_tok       <= i_tok;
            r_b_tok       <= r_a_tok;
            r_c_tok       <= r_b_tok;
            r_d_tok.valid <= r_c_tok.valid;
            r_d_tok.hit   <= r_c_tok.valid && (r_c_tok.hit || (r_c_live && w_touch));
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        r_a_step <= i_step;
        r_a_idx  <= i_idx;

        r_b_step <= r_a_step;
        r_b_idx  <= r_a_idx;
        r_b_ent  <= w_ent;
        r_b_live <= w_live;
        r_b_box  <= w_box;
        for (int k = 0; k < 8; k++) begin
            r_b_ma[k] <= w_ma[k];
            r_b_mb[k] <= w_mb[k];
        end

        r_c_step <= r_b_step;
        r_c_idx  <= r_b_idx;
        r_c_ent  <= r_b_ent;
        r_c_live <= r_b_live;
        r_c_box  <= r_b_box;
        for (int k = 0; k < 8; k++) begin
            r_c_p[k] <= r_b_ma[k] * r_b_mb[k];
        end

        // keep an earlier hit, else record this entry
        r_d_step <= r_c_step;
        r_d_idx  <= r_c_tok.hit ? r_c_idx : r_c_ent;
    end

    assign o_tok  = r_d_tok;
    assign o_step = r_d_step;
    assign o_idx  = r_d_idx;

endmodule

// File: hw/rtl/segment_obstacle_clearance_check.sv
// a query checking n segments walks four interleaved table banks one step per cycle,
// each step passing through the cell chain (4 cells of 4 stages); issue stops once a
// hit returns, and a query with n = 0 goes straight to its result
// throughput: one query at a time; loads are taken whenever no query is in flight
// reset: synchronous, clears control and segment_count; table contents undefined
// until written, no clearing pass
`timescale 1ns / 1ps

module segment_obstacle_clearance_check #(
    parameter int SEG_DEPTH = 1024,
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_cmd,
    input  logic [soc_pkg::SLOT_W-1:0]    i_slot,
    input  logic signed [soc_pkg::FIELD_W-1:0] i_start_x,
    input  logic signed [soc_pkg::FIELD_W-1:0] i_start_y,
    input  logic signed [soc_pkg::FIELD_W-1:0] i_end_x,
    input  logic signed [soc_pkg::FIELD_W-1:0] i_end_y,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_path_free,
    output logic [soc_pkg::HIT_W-1:0]     o_first_hit,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [soc_pkg::APB_AW-1:0]    paddr,
    input  logic [soc_pkg::APB_DW-1:0]    pwdata,
    output logic [soc_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    import soc_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int BANK_DEPTH = (SEG_DEPTH + CELLS - 1) / CELLS;
    localparam int BA_W = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int IDX_W = BA_W + CELL_BITS;
    localparam int CNT_W = $clog2(SEG_DEPTH + 1);
    localparam int SC_W = BA_W + 1;
    localparam int IF_W = $clog2(CHAIN_LAT + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // take a coordinate as the low COORD_BITS bits of its field, without sign extension
    function automatic logic [CW-1:0] f_coord(input logic [FIELD_W-1:0] f);
        logic [31:0] w;
        w = {{(32 - FIELD_W){1'b0}}, f};
        f_coord = w[CW-1:0];
    endfunction

    logic [1:0]       r_state, n_state;
    logic [SC_W-1:0]  r_issue, n_issue;
    logic [IF_W-1:0]  r_inflight, n_inflight;
    logic             r_found, n_found;
    logic             r_out_valid, n_out_valid;
    logic [COUNT_W-1:0] r_seg_count;
    logic [4*CW-1:0]  r_query;
    logic [CNT_W-1:0] r_n;
    logic [SC_W-1:0]  r_steps;
    logic [IDX_W-1:0] r_hit_idx;
    logic             r_out_free;
    logic [HIT_W-1:0] r_out_hit;

    logic             w_in_acc, w_out_acc, w_cfg_wr, w_ld_ok, w_query;
    logic             w_issue, w_recv, w_out_load;
    logic [CNT_W-1:0] w_n;
    logic [SC_W-1:0]  w_steps;
    logic [4*CW-1:0]  w_seg;

    t_tok             w_tok  [CELLS+1];
    logic [BA_W-1:0]  w_step [CELLS+1];
    logic [IDX_W-1:0] w_idx  [CELLS+1];

    // handshakes
    assign o_stall   = (r_state != ST_IDLE);
    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = r_out_valid && !i_stall;
    assign w_query   = w_in_acc && (i_cmd == CMD_QUERY);
    assign w_ld_ok   = w_in_acc && (i_cmd == CMD_LOAD) && (32'(i_slot) < 32'(SEG_DEPTH));
    assign w_seg     = {f_coord(i_start_x), f_coord(i_start_y),
                        f_coord(i_end_x), f_coord(i_end_y)};

    // configuration register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_SEG_COUNT) ? APB_DW'(r_seg_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count <= '0;
        end else if (w_cfg_wr && paddr[2] == REG_SEG_COUNT) begin
            r_seg_count <= pwdata[COUNT_W-1:0];
        end
    end

    // effective count, saturated to the table depth, and scan steps
    always_comb begin
        if (32'(r_seg_count) > 32'(SEG_DEPTH)) begin
            w_n = CNT_W'(SEG_DEPTH);
        end else begin
            w_n = CNT_W'(r_seg_count);
        end
        w_steps = SC_W'((32'(w_n) + 32'(CELLS - 1)) >> CELL_BITS);
    end

    // token issue into the head of the chain and collection at its tail
    assign w_issue = (r_state == ST_SCAN) && !r_found && (r_issue != r_steps);
    assign w_recv  = w_tok[CELLS].valid;

    assign w_tok[0].valid = w_issue;
    assign w_tok[0].hit   = 1'b0;
    assign w_step[0]      = r_issue[BA_W-1:0];
    assign w_idx[0]       = '0;

    // cell chain
    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        soc_cell #(
            .CW        (CW),
            .BANK_DEPTH(BANK_DEPTH),
            .BA_W      (BA_W),
            .CNT_W     (CNT_W),
            .CELL_ID   (k)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_we   (w_ld_ok && (i_slot[CELL_BITS-1:0] == CELL_BITS'(k))),
            .i_waddr(BA_W'(i_slot >> CELL_BITS)),
            .i_wdata(w_seg),
            .i_query(r_query),
            .i_count(r_n),
            .i_tok  (w_tok[k]),
            .i_step (w_step[k]),
            .i_idx  (w_idx[k]),
            .o_tok  (w_tok[k+1]),
            .o_step (w_step[k+1]),
            .o_idx  (w_idx[k+1])
        );
    end

    // control sequencer
    always_comb begin
        n_state     = r_state;
        n_issue     = r_issue;
        n_found     = r_found;
        n_inflight  = r_inflight + IF_W'(w_issue) - IF_W'(w_recv);
        w_out_load  = 1'b0;
        if (w_issue) begin
            n_issue = r_issue + 1'b1;
        end
        if (w_recv && w_tok[CELLS].hit) begin
            n_found = 1'b1;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_query) begin
                    n_issue = '0;
                    n_found = 1'b0;
                    n_state = (w_n == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!w_issue && r_inflight == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || w_out_acc) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (w_out_acc) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issue     <= '0;
            r_inflight  <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issue     <= n_issue;
            r_inflight  <= n_inflight;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    // query operands, first hit and result register
    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_query <= w_seg;
            r_n     <= w_n;
            r_steps <= w_steps;
        end
        if (w_recv && w_tok[CELLS].hit && !r_found) begin
            r_hit_idx <= w_idx[CELLS];
        end
        if (w_out_load) begin
            r_out_free <= !r_found;
            r_out_hit  <= r_found ? HIT_W'(r_hit_idx) : '0;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_path_free = r_out_free;
    assign o_first_hit = r_out_hit;

    // tokens in flight never exceed the chain depth
    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= IF_W'(CHAIN_LAT))
        else $error("scan tokens in flight exceed chain depth");

    // tokens only leave the chain while a scan is running
    a_recv_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_recv |-> r_state == ST_SCAN)
        else $error("scan token left the chain outside a scan");

    // a free path always reports hit index zero
    a_free_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_path_free) |-> o_first_hit == '0)
        else $error("free path with nonzero hit index");

    // an accepted query is followed by the scan or done state, so no item is taken before its result
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_query |=> (r_state == ST_SCAN || r_state == ST_DONE))
        else $error("query accepted without starting a scan");

endmodule
